/* sv/aabb_frustum_cull_top_defines.svh */
// -----------------------------------------------------------------------------
// Frustum cull assertion macros
// Shared property templates for the box culling pipeline checks.
// -----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_TOP_DEFINES_SVH
`define AABB_FRUSTUM_CULL_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define AFC_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("aabb_frustum_cull: same-cycle check failed");

// next-cycle implication, off during reset
`define AFC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("aabb_frustum_cull: next-cycle check failed");

`endif

/* sv/aabb_fc_pkg.sv */
// -----------------------------------------------------------------------------
// Frustum cull package
// Field widths, payload structs, codes and inter-stage types.
// -----------------------------------------------------------------------------
package aabb_fc_pkg;

	localparam int COORD_W  = 32;
	localparam int COMP_W   = 16;
	localparam int VEC_W    = 3 * COMP_W;
	localparam int TAN_W    = 16;
	localparam int CFG_W    = VEC_W;
	localparam int D_W      = COORD_W + 3;
	localparam int E_W      = COORD_W + 1;
	localparam int PD_W     = D_W + COMP_W;
	localparam int PE_W     = E_W + COMP_W + 1;
	localparam int CS_W     = PD_W + 2;
	localparam int RS_W     = PE_W + 2;
	localparam int TS_W     = CS_W + 1;
	localparam int MAG_W    = CS_W;
	localparam int SHIFT    = 14;
	localparam int PROD_W   = MAG_W + TAN_W;

	localparam logic [TAN_W-1:0] TAN_RESET = TAN_W'(16384);
	localparam logic signed [TS_W-1:0] NEAR_Q23 = TS_W'(64'sd98304);
	localparam logic signed [TS_W-1:0] FAR_Q23  = TS_W'(64'sd8388608000);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
	} box_t;

	typedef enum logic [2:0] {
		VERDICT_DEGENERATE = 3'd0,
		VERDICT_CAM_INSIDE = 3'd1,
		VERDICT_NEAR       = 3'd2,
		VERDICT_FAR        = 3'd3,
		VERDICT_HORIZONTAL = 3'd4,
		VERDICT_VERTICAL   = 3'd5,
		VERDICT_PASSED     = 3'd6
	} verdict_t;

	typedef struct packed {
		logic     visible;
		verdict_t verdict;
	} result_t;

	typedef enum logic [2:0] {
		CFG_CAM_POS_X = 3'd0,
		CFG_CAM_POS_Y = 3'd1,
		CFG_CAM_POS_Z = 3'd2,
		CFG_FORWARD   = 3'd3,
		CFG_RIGHT     = 3'd4,
		CFG_UP        = 3'd5,
		CFG_TAN_V     = 3'd6,
		CFG_TAN_H     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic same;
		logic cam_in;
	} flags_t;

	typedef struct packed {
		flags_t                flags;
		logic [2:0][D_W-1:0]   d;
		logic [2:0][E_W-1:0]   e;
	} prep_t;

	typedef struct packed {
		flags_t          flags;
		logic [CS_W-1:0] cf;
		logic [CS_W-1:0] cr;
		logic [CS_W-1:0] cu;
		logic [RS_W-1:0] rf;
		logic [RS_W-1:0] rr;
		logic [RS_W-1:0] ru;
	} proj_t;

	function automatic logic [COMP_W-1:0] abs_comp(input logic [COMP_W-1:0] c);
		return c[COMP_W-1] ? (~c + COMP_W'(1)) : c;
	endfunction

endpackage

/* sv/aabb_fc_prep.sv */
// -----------------------------------------------------------------------------
// Frustum cull prep stage
// Doubled center offset, extent and the degenerate / camera-inside flags.
// -----------------------------------------------------------------------------
module aabb_fc_prep (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  aabb_fc_pkg::box_t     box,
	input  aabb_fc_pkg::coord_t   pos_x,
	input  aabb_fc_pkg::coord_t   pos_y,
	input  aabb_fc_pkg::coord_t   pos_z,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output aabb_fc_pkg::prep_t    dn
);

	aabb_fc_pkg::coord_t mn [3];
	aabb_fc_pkg::coord_t mx [3];
	aabb_fc_pkg::coord_t pos [3];
	aabb_fc_pkg::prep_t  nxt;
	aabb_fc_pkg::prep_t  data_s1;
	logic                v_s1;

	always_comb begin
		mn[0]  = box.box_min_x;
		mn[1]  = box.box_min_y;
		mn[2]  = box.box_min_z;
		mx[0]  = box.box_max_x;
		mx[1]  = box.box_max_y;
		mx[2]  = box.box_max_z;
		pos[0] = pos_x;
		pos[1] = pos_y;
		pos[2] = pos_z;
		nxt.flags.same   = 1'b1;
		nxt.flags.cam_in = 1'b1;
		for (int k = 0; k < 3; k++) begin
			nxt.d[k] = aabb_fc_pkg::D_W'(mn[k]) + aabb_fc_pkg::D_W'(mx[k])
				- (aabb_fc_pkg::D_W'(pos[k]) <<< 1);
			nxt.e[k] = aabb_fc_pkg::E_W'(mx[k]) - aabb_fc_pkg::E_W'(mn[k]);
			if (mn[k] != mx[k]) begin
				nxt.flags.same = 1'b0;
			end
			if (pos[k] < mn[k] || pos[k] > mx[k]) begin
				nxt.flags.cam_in = 1'b0;
			end
		end
	end

	assign up_ready = !v_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = v_s1;
	assign dn       = data_s1;

endmodule

/* sv/aabb_fc_proj.sv */
// -----------------------------------------------------------------------------
// Frustum cull projection
// Projects center and extent on the camera basis: products, then sums.
// -----------------------------------------------------------------------------
module aabb_fc_proj (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  up_valid,
	output logic                                  up_ready,
	input  aabb_fc_pkg::prep_t                    up,
	input  logic [aabb_fc_pkg::VEC_W-1:0]         fwd,
	input  logic [aabb_fc_pkg::VEC_W-1:0]         rgt,
	input  logic [aabb_fc_pkg::VEC_W-1:0]         upv,
	output logic                                  dn_valid,
	input  logic                                  dn_ready,
	output aabb_fc_pkg::proj_t                    dn
);

	localparam int CW = aabb_fc_pkg::COMP_W;

	logic signed [aabb_fc_pkg::PD_W-1:0] pdf [3];
	logic signed [aabb_fc_pkg::PD_W-1:0] pdr [3];
	logic signed [aabb_fc_pkg::PD_W-1:0] pdu [3];
	logic signed [aabb_fc_pkg::PE_W-1:0] pef [3];
	logic signed [aabb_fc_pkg::PE_W-1:0] per [3];
	logic signed [aabb_fc_pkg::PE_W-1:0] peu [3];

	logic signed [aabb_fc_pkg::PD_W-1:0] pdf_s2 [3];
	logic signed [aabb_fc_pkg::PD_W-1:0] pdr_s2 [3];
	logic signed [aabb_fc_pkg::PD_W-1:0] pdu_s2 [3];
	logic signed [aabb_fc_pkg::PE_W-1:0] pef_s2 [3];
	logic signed [aabb_fc_pkg::PE_W-1:0] per_s2 [3];
	logic signed [aabb_fc_pkg::PE_W-1:0] peu_s2 [3];
	aabb_fc_pkg::flags_t                 flags_s2;
	logic                                v_s2;

	aabb_fc_pkg::proj_t                  nxt;
	aabb_fc_pkg::proj_t                  data_s3;
	logic                                v_s3;

	logic                                en_s2;
	logic                                en_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pdf[k] = $signed(up.d[k]) * $signed(fwd[CW*k +: CW]);
			pdr[k] = $signed(up.d[k]) * $signed(rgt[CW*k +: CW]);
			pdu[k] = $signed(up.d[k]) * $signed(upv[CW*k +: CW]);
			pef[k] = $signed(up.e[k])
				* $signed({1'b0, aabb_fc_pkg::abs_comp(fwd[CW*k +: CW])});
			per[k] = $signed(up.e[k])
				* $signed({1'b0, aabb_fc_pkg::abs_comp(rgt[CW*k +: CW])});
			peu[k] = $signed(up.e[k])
				* $signed({1'b0, aabb_fc_pkg::abs_comp(upv[CW*k +: CW])});
		end
	end

	always_comb begin
		nxt.flags = flags_s2;
		nxt.cf = aabb_fc_pkg::CS_W'(pdf_s2[0]) + aabb_fc_pkg::CS_W'(pdf_s2[1])
			+ aabb_fc_pkg::CS_W'(pdf_s2[2]);
		nxt.cr = aabb_fc_pkg::CS_W'(pdr_s2[0]) + aabb_fc_pkg::CS_W'(pdr_s2[1])
			+ aabb_fc_pkg::CS_W'(pdr_s2[2]);
		nxt.cu = aabb_fc_pkg::CS_W'(pdu_s2[0]) + aabb_fc_pkg::CS_W'(pdu_s2[1])
			+ aabb_fc_pkg::CS_W'(pdu_s2[2]);
		nxt.rf = aabb_fc_pkg::RS_W'(pef_s2[0]) + aabb_fc_pkg::RS_W'(pef_s2[1])
			+ aabb_fc_pkg::RS_W'(pef_s2[2]);
		nxt.rr = aabb_fc_pkg::RS_W'(per_s2[0]) + aabb_fc_pkg::RS_W'(per_s2[1])
			+ aabb_fc_pkg::RS_W'(per_s2[2]);
		nxt.ru = aabb_fc_pkg::RS_W'(peu_s2[0]) + aabb_fc_pkg::RS_W'(peu_s2[1])
			+ aabb_fc_pkg::RS_W'(peu_s2[2]);
	end

	assign en_s3    = !v_s3 || dn_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign up_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= up_valid;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && up_valid) begin
			flags_s2 <= up.flags;
			for (int k = 0; k < 3; k++) begin
				pdf_s2[k] <= pdf[k];
				pdr_s2[k] <= pdr[k];
				pdu_s2[k] <= pdu[k];
				pef_s2[k] <= pef[k];
				per_s2[k] <= per[k];
				peu_s2[k] <= peu[k];
			end
		end
		if (en_s3 && v_s2) begin
			data_s3 <= nxt;
		end
	end

	assign dn_valid = v_s3;
	assign dn       = data_s3;

endmodule

/* sv/aabb_fc_test.sv */
// -----------------------------------------------------------------------------
// Frustum cull plane and slope tests
// Near/far checks, slope products, compare and verdict output register.
// -----------------------------------------------------------------------------
module aabb_fc_test (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            up_valid,
	output logic                            up_ready,
	input  aabb_fc_pkg::proj_t              up,
	input  logic [aabb_fc_pkg::TAN_W-1:0]   tan_v,
	input  logic [aabb_fc_pkg::TAN_W-1:0]   tan_h,
	output logic                            dn_valid,
	input  logic                            dn_ready,
	output aabb_fc_pkg::result_t            dn
);

	localparam int MW = aabb_fc_pkg::MAG_W;
	localparam int TW = aabb_fc_pkg::TS_W;
	localparam int PW = aabb_fc_pkg::PROD_W;

	logic signed [aabb_fc_pkg::CS_W-1:0] cf;
	logic signed [aabb_fc_pkg::CS_W-1:0] cr;
	logic signed [aabb_fc_pkg::CS_W-1:0] cu;
	logic signed [aabb_fc_pkg::RS_W-1:0] rf;
	logic signed [aabb_fc_pkg::RS_W-1:0] rr;
	logic signed [aabb_fc_pkg::RS_W-1:0] ru;
	logic signed [TW-1:0]                fsum;
	logic signed [TW-1:0]                fdiff;
	logic [MW-1:0]                       abs_cr;
	logic [MW-1:0]                       abs_cu;
	logic signed [TW-1:0]                ar;
	logic signed [TW-1:0]                au;

	aabb_fc_pkg::flags_t flags_s4;
	logic                near_s4;
	logic                far_s4;
	logic [MW-1:0]       fmax_s4;
	logic                ar_pos_s4;
	logic                au_pos_s4;
	logic [MW-1:0]       ar_s4;
	logic [MW-1:0]       au_s4;
	logic                v_s4;

	aabb_fc_pkg::flags_t flags_s5;
	logic                near_s5;
	logic                far_s5;
	logic                ar_pos_s5;
	logic                au_pos_s5;
	logic [MW-1:0]       ar_s5;
	logic [MW-1:0]       au_s5;
	logic [PW-1:0]       prod_h_s5;
	logic [PW-1:0]       prod_v_s5;
	logic                v_s5;

	logic                 out_h;
	logic                 out_v;
	aabb_fc_pkg::result_t nxt;
	aabb_fc_pkg::result_t res_s6;
	logic                 v_s6;

	logic en_s4;
	logic en_s5;
	logic en_s6;

	always_comb begin
		cf     = $signed(up.cf);
		cr     = $signed(up.cr);
		cu     = $signed(up.cu);
		rf     = $signed(up.rf);
		rr     = $signed(up.rr);
		ru     = $signed(up.ru);
		fsum   = TW'(cf) + TW'(rf);
		fdiff  = TW'(cf) - TW'(rf);
		abs_cr = cr[aabb_fc_pkg::CS_W-1] ? MW'(-cr) : MW'(cr);
		abs_cu = cu[aabb_fc_pkg::CS_W-1] ? MW'(-cu) : MW'(cu);
		ar     = $signed({1'b0, abs_cr}) - TW'(rr);
		au     = $signed({1'b0, abs_cu}) - TW'(ru);
	end

	always_comb begin
		out_h = ar_pos_s5 && ((PW'(ar_s5) << aabb_fc_pkg::SHIFT) > prod_h_s5);
		out_v = au_pos_s5 && ((PW'(au_s5) << aabb_fc_pkg::SHIFT) > prod_v_s5);
		priority if (flags_s5.same) begin
			nxt.verdict = aabb_fc_pkg::VERDICT_DEGENERATE;
		end else if (flags_s5.cam_in) begin
			nxt.verdict = aabb_fc_pkg::VERDICT_CAM_INSIDE;
		end else if (near_s5) begin
			nxt.verdict = aabb_fc_pkg::VERDICT_NEAR;
		end else if (far_s5) begin
			nxt.verdict = aabb_fc_pkg::VERDICT_FAR;
		end else if (out_h) begin
			nxt.verdict = aabb_fc_pkg::VERDICT_HORIZONTAL;
		end else if (out_v) begin
			nxt.verdict = aabb_fc_pkg::VERDICT_VERTICAL;
		end else begin
			nxt.verdict = aabb_fc_pkg::VERDICT_PASSED;
		end
		nxt.visible = (nxt.verdict == aabb_fc_pkg::VERDICT_CAM_INSIDE)
			|| (nxt.verdict == aabb_fc_pkg::VERDICT_PASSED);
	end

	assign en_s6    = !v_s6 || dn_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign up_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4 <= up_valid;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && up_valid) begin
			flags_s4  <= up.flags;
			near_s4   <= fsum < aabb_fc_pkg::NEAR_Q23;
			far_s4    <= fdiff > aabb_fc_pkg::FAR_Q23;
			fmax_s4   <= (fsum < aabb_fc_pkg::NEAR_Q23) ? MW'(aabb_fc_pkg::NEAR_Q23)
				: MW'(fsum);
			ar_pos_s4 <= !ar[TW-1] && (ar != '0);
			au_pos_s4 <= !au[TW-1] && (au != '0);
			ar_s4     <= MW'(ar);
			au_s4     <= MW'(au);
		end
		if (en_s5 && v_s4) begin
			flags_s5  <= flags_s4;
			near_s5   <= near_s4;
			far_s5    <= far_s4;
			ar_pos_s5 <= ar_pos_s4;
			au_pos_s5 <= au_pos_s4;
			ar_s5     <= ar_s4;
			au_s5     <= au_s4;
			prod_h_s5 <= PW'(fmax_s4) * PW'(tan_h);
			prod_v_s5 <= PW'(fmax_s4) * PW'(tan_v);
		end
		if (en_s6 && v_s5) begin
			res_s6 <= nxt;
		end
	end

	assign dn_valid = v_s6;
	assign dn       = res_s6;

endmodule

/* sv/aabb_frustum_cull_top.sv */
// -----------------------------------------------------------------------------
// AABB view-frustum cull
// Takes one box per clock when nothing stalls and returns one verdict per
// box, in order. The pipeline is six register stages deep (corner prep,
// basis products, basis sums, near/far and slope operands, slope products,
// compare and verdict). Each stage holds its item only while the next one
// is full and stalled, so box_ready stays high as long as any stage has
// room; the rate is one box per cycle while res_ready is high. Camera
// registers are taken on cfg_valid at any time (cfg_ready is always high)
// and must only change while no box is in flight.
// -----------------------------------------------------------------------------
`include "aabb_frustum_cull_top_defines.svh"

module aabb_frustum_cull_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               box_valid,
	output logic                               box_ready,
	input  aabb_fc_pkg::box_t                  box,
	output logic                               res_valid,
	input  logic                               res_ready,
	output aabb_fc_pkg::result_t               res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [2:0]                         cfg_index,
	input  logic [aabb_fc_pkg::CFG_W-1:0]      cfg_data
);

	aabb_fc_pkg::coord_t                 cam_pos_x_q;
	aabb_fc_pkg::coord_t                 cam_pos_y_q;
	aabb_fc_pkg::coord_t                 cam_pos_z_q;
	logic [aabb_fc_pkg::VEC_W-1:0]       forward_q;
	logic [aabb_fc_pkg::VEC_W-1:0]       right_q;
	logic [aabb_fc_pkg::VEC_W-1:0]       up_q;
	logic [aabb_fc_pkg::TAN_W-1:0]       tan_v_q;
	logic [aabb_fc_pkg::TAN_W-1:0]       tan_h_q;

	logic                prep_valid;
	logic                prep_ready;
	aabb_fc_pkg::prep_t  prep;
	logic                proj_valid;
	logic                proj_ready;
	aabb_fc_pkg::proj_t  proj;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_pos_x_q <= '0;
			cam_pos_y_q <= '0;
			cam_pos_z_q <= '0;
			forward_q   <= '0;
			right_q     <= '0;
			up_q        <= '0;
			tan_v_q     <= aabb_fc_pkg::TAN_RESET;
			tan_h_q     <= aabb_fc_pkg::TAN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (aabb_fc_pkg::cfg_idx_t'(cfg_index))
				aabb_fc_pkg::CFG_CAM_POS_X: begin
					cam_pos_x_q <= cfg_data[aabb_fc_pkg::COORD_W-1:0];
				end
				aabb_fc_pkg::CFG_CAM_POS_Y: begin
					cam_pos_y_q <= cfg_data[aabb_fc_pkg::COORD_W-1:0];
				end
				aabb_fc_pkg::CFG_CAM_POS_Z: begin
					cam_pos_z_q <= cfg_data[aabb_fc_pkg::COORD_W-1:0];
				end
				aabb_fc_pkg::CFG_FORWARD: begin
					forward_q <= cfg_data[aabb_fc_pkg::VEC_W-1:0];
				end
				aabb_fc_pkg::CFG_RIGHT: begin
					right_q <= cfg_data[aabb_fc_pkg::VEC_W-1:0];
				end
				aabb_fc_pkg::CFG_UP: begin
					up_q <= cfg_data[aabb_fc_pkg::VEC_W-1:0];
				end
				aabb_fc_pkg::CFG_TAN_V: begin
					tan_v_q <= cfg_data[aabb_fc_pkg::TAN_W-1:0];
				end
				aabb_fc_pkg::CFG_TAN_H: begin
					tan_h_q <= cfg_data[aabb_fc_pkg::TAN_W-1:0];
				end
				default: begin
					tan_h_q <= tan_h_q;
				end
			endcase
		end
	end

	aabb_fc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (box_valid),
		.up_ready (box_ready),
		.box      (box),
		.pos_x    (cam_pos_x_q),
		.pos_y    (cam_pos_y_q),
		.pos_z    (cam_pos_z_q),
		.dn_valid (prep_valid),
		.dn_ready (prep_ready),
		.dn       (prep)
	);

	aabb_fc_proj u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (prep_valid),
		.up_ready (prep_ready),
		.up       (prep),
		.fwd      (forward_q),
		.rgt      (right_q),
		.upv      (up_q),
		.dn_valid (proj_valid),
		.dn_ready (proj_ready),
		.dn       (proj)
	);

	aabb_fc_test u_test (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (proj_valid),
		.up_ready (proj_ready),
		.up       (proj),
		.tan_v    (tan_v_q),
		.tan_h    (tan_h_q),
		.dn_valid (res_valid),
		.dn_ready (res_ready),
		.dn       (res)
	);

	`AFC_ASSERT_IMP(a_visible_matches_verdict, clk, arst_n, res_valid, (res.visible == ((res.verdict == aabb_fc_pkg::VERDICT_CAM_INSIDE) || (res.verdict == aabb_fc_pkg::VERDICT_PASSED))))
	`AFC_ASSERT_IMP(a_free_output_opens_input, clk, arst_n, (!res_valid || res_ready), box_ready)
	`AFC_ASSERT_NEXT(a_transfer_enters_prep, clk, arst_n, (box_valid && box_ready), prep_valid)

endmodule
